FILE: hdl/clnw_pkg.sv
// types, codes and helpers shared by the character lcd nibble writer
`default_nettype none
package clnw_pkg;

    localparam int NIB_MAX   = 12;
    localparam int CNT_W     = 4;
    localparam int BYTE_MAX  = NIB_MAX / 2;
    localparam int DIGITS    = 5;
    localparam int BIN_W     = 16;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int DD_W      = BCD_W + BIN_W;
    localparam int DD_STEPS  = 4;
    localparam int DD_STAGES = BIN_W / DD_STEPS;

    typedef enum logic [2:0] {
        ACT_INIT    = 3'd0,
        ACT_CMD     = 3'd1,
        ACT_CHAR    = 3'd2,
        ACT_NUM     = 3'd3,
        ACT_NUM_POS = 3'd4,
        ACT_POS     = 3'd5,
        ACT_CURSOR  = 3'd6
    } action_t;

    localparam logic [1:0] CUR_OFF   = 2'd0;
    localparam logic [1:0] CUR_BLINK = 2'd1;

    localparam logic [7:0] LINE1_BASE   = 8'h80;
    localparam logic [7:0] LINE2_BASE   = 8'hC0;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] CMD_CUR_OFF  = 8'h0C;
    localparam logic [7:0] CMD_CUR_BLNK = 8'h0F;
    localparam logic [1:0] ROW_FIRST    = 2'd1;

    typedef struct packed {
        logic [3:0] nib;
        logic       rs;
    } nib_ent_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [BIN_W-1:0] value;
        logic [5:0]       column;
        logic [1:0]       row;
        logic [1:0]       choice;
    } req_t;

    typedef logic [DD_W-1:0] dd_t;

    // wake-up nibbles, then function set, display off, display on, clear
    localparam nib_ent_t INIT_SEQ [NIB_MAX] = '{
        '{4'h3, 1'b0}, '{4'h3, 1'b0}, '{4'h3, 1'b0}, '{4'h2, 1'b0},
        '{4'h2, 1'b0}, '{4'h8, 1'b0}, '{4'h0, 1'b0}, '{4'h8, 1'b0},
        '{4'h0, 1'b0}, '{4'hC, 1'b0}, '{4'h0, 1'b0}, '{4'h1, 1'b0}
    };

    // a few rounds of shift-and-add-three binary to bcd conversion
    function automatic dd_t dabble_steps(input dd_t s);
        dd_t t;
        t = s;
        for (int i = 0; i < DD_STEPS; i++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (t[BIN_W + 4*d +: 4] >= 4'd5)
                begin
                    t[BIN_W + 4*d +: 4] = t[BIN_W + 4*d +: 4] + 4'd3;
                end
            end
            t = {t[DD_W-2:0], 1'b0};
        end
        return t;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/clnw_req_if.sv
// request channel: one lcd request per beat
`default_nettype none
interface clnw_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] value;
    logic [5:0]  column;
    logic [1:0]  row;
    logic [1:0]  cursor_choice;

    modport source (output valid, action, value, column, row, cursor_choice, input ready);
    modport sink   (input valid, action, value, column, row, cursor_choice, output ready);
endinterface
`default_nettype wire

FILE: hdl/clnw_nib_if.sv
// nibble channel: one bus write per beat
`default_nettype none
interface clnw_nib_if;
    logic       valid;
    logic       ready;
    logic [3:0] nibble;
    logic       register_select;
    logic       last;

    modport source (output valid, nibble, register_select, last, input ready);
    modport sink   (input valid, nibble, register_select, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/char_lcd_nibble_writer_unit.sv
// Character lcd nibble writer. Each request beat is turned into 0 to 12 nibble
// beats for an lcd in 4-bit mode, high nibble first, the final one flagged by
// last. A request passes a capture stage, four binary-to-decimal stages and a
// sequence build stage, then a 12-entry shift register sends one nibble per
// cycle while nib.ready is high. An init request gives 12 nibbles. All stages
// stall together while a built run waits for the shift register; a waiting run
// starts in the cycle after the previous last beat. Requests that give no
// nibbles pass through and never hold the stages.
`default_nettype none
module char_lcd_nibble_writer_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    clnw_req_if.sink    req,
    clnw_nib_if.source  nib
);

    localparam int NS = clnw_pkg::DD_STAGES + 1;

    logic                      vld_reg [NS];
    clnw_pkg::req_t            rq_reg  [NS];
    clnw_pkg::dd_t             dd_reg  [NS];

    logic                      bvld_reg;
    logic [clnw_pkg::CNT_W-1:0] bcnt_reg, bcnt_next;
    clnw_pkg::nib_ent_t        blist_reg [clnw_pkg::NIB_MAX];
    clnw_pkg::nib_ent_t        blist_next [clnw_pkg::NIB_MAX];

    logic [clnw_pkg::CNT_W-1:0] rem_reg, rem_next;
    clnw_pkg::nib_ent_t        sh_reg [clnw_pkg::NIB_MAX];
    clnw_pkg::nib_ent_t        sh_next [clnw_pkg::NIB_MAX];

    logic adv, can_load, load, beat;

    assign beat     = nib.valid && nib.ready;
    assign can_load = (rem_reg == '0) || ((rem_reg == clnw_pkg::CNT_W'(1)) && nib.ready);
    assign adv      = !bvld_reg || (bcnt_reg == '0) || can_load;
    assign load     = adv && bvld_reg && (bcnt_reg != '0);
    assign req.ready = adv;

    // capture, decimal conversion and build stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            bvld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= req.valid;
            for (int k = 1; k < NS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            bvld_reg <= vld_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rq_reg[0] <= '{action: req.action, value: req.value, column: req.column,
                           row: req.row, choice: req.cursor_choice};
            dd_reg[0] <= {{clnw_pkg::BCD_W{1'b0}}, req.value};
            for (int k = 1; k < NS; k++)
            begin
                rq_reg[k] <= rq_reg[k-1];
                dd_reg[k] <= clnw_pkg::dabble_steps(dd_reg[k-1]);
            end
            bcnt_reg  <= bcnt_next;
            blist_reg <= blist_next;
        end
    end

    // sequence build from request and decimal digits
    logic [3:0] dig [clnw_pkg::DIGITS];
    logic [3:0] dl  [clnw_pkg::DIGITS];
    logic [2:0] nd;
    logic [7:0] pos_byte;
    logic [7:0] bytes [clnw_pkg::BYTE_MAX];
    logic       brs   [clnw_pkg::BYTE_MAX];
    logic [2:0] nbytes;
    logic       use_bytes;
    clnw_pkg::req_t rb;

    always_comb
    begin
        rb = rq_reg[NS-1];
        for (int d = 0; d < clnw_pkg::DIGITS; d++)
        begin
            dig[d] = dd_reg[NS-1][clnw_pkg::BIN_W + 4*d +: 4];
        end
        if (dig[4] != 4'd0)      nd = 3'd5;
        else if (dig[3] != 4'd0) nd = 3'd4;
        else if (dig[2] != 4'd0) nd = 3'd3;
        else if (dig[1] != 4'd0) nd = 3'd2;
        else                     nd = 3'd1;
        // most significant kept digit goes first
        for (int k = 0; k < clnw_pkg::DIGITS; k++)
        begin
            if (3'(k) < nd) dl[k] = dig[3'(nd - 3'(k) - 3'd1)];
            else            dl[k] = 4'd0;
        end
        pos_byte = ((rb.row == clnw_pkg::ROW_FIRST) ? clnw_pkg::LINE1_BASE
                                                    : clnw_pkg::LINE2_BASE)
                   + {2'b00, rb.column} - 8'd1;

        for (int k = 0; k < clnw_pkg::BYTE_MAX; k++)
        begin
            bytes[k] = 8'd0;
            brs[k]   = 1'b0;
        end
        nbytes    = 3'd0;
        use_bytes = 1'b1;

        case (clnw_pkg::action_t'(rb.action))
            clnw_pkg::ACT_INIT:
            begin
                use_bytes = 1'b0;
            end
            clnw_pkg::ACT_CMD:
            begin
                bytes[0] = rb.value[7:0];
                nbytes   = 3'd1;
            end
            clnw_pkg::ACT_CHAR:
            begin
                bytes[0] = rb.value[7:0];
                brs[0]   = 1'b1;
                nbytes   = 3'd1;
            end
            clnw_pkg::ACT_NUM:
            begin
                for (int k = 0; k < clnw_pkg::DIGITS; k++)
                begin
                    bytes[k] = clnw_pkg::ASCII_ZERO | {4'd0, dl[k]};
                    brs[k]   = 1'b1;
                end
                nbytes = nd;
            end
            clnw_pkg::ACT_NUM_POS:
            begin
                bytes[0] = pos_byte;
                for (int k = 0; k < clnw_pkg::DIGITS; k++)
                begin
                    bytes[k+1] = clnw_pkg::ASCII_ZERO | {4'd0, dl[k]};
                    brs[k+1]   = 1'b1;
                end
                nbytes = nd + 3'd1;
            end
            clnw_pkg::ACT_POS:
            begin
                bytes[0] = pos_byte;
                nbytes   = 3'd1;
            end
            clnw_pkg::ACT_CURSOR:
            begin
                if (rb.choice == clnw_pkg::CUR_OFF)
                begin
                    bytes[0] = clnw_pkg::CMD_CUR_OFF;
                    nbytes   = 3'd1;
                end
                else if (rb.choice == clnw_pkg::CUR_BLINK)
                begin
                    bytes[0] = clnw_pkg::CMD_CUR_BLNK;
                    nbytes   = 3'd1;
                end
            end
            default:
            begin
                nbytes = 3'd0;
            end
        endcase

        if (use_bytes)
        begin
            for (int k = 0; k < clnw_pkg::BYTE_MAX; k++)
            begin
                blist_next[2*k]   = '{nib: bytes[k][7:4], rs: brs[k]};
                blist_next[2*k+1] = '{nib: bytes[k][3:0], rs: brs[k]};
            end
            bcnt_next = {nbytes, 1'b0};
        end
        else
        begin
            blist_next = clnw_pkg::INIT_SEQ;
            bcnt_next  = clnw_pkg::CNT_W'(clnw_pkg::NIB_MAX);
        end
    end

    // output shift register, entry zero is on the bus
    always_comb
    begin
        sh_next  = sh_reg;
        rem_next = rem_reg;
        if (load)
        begin
            sh_next  = blist_reg;
            rem_next = bcnt_reg;
        end
        else if (beat)
        begin
            for (int k = 0; k < clnw_pkg::NIB_MAX - 1; k++)
            begin
                sh_next[k] = sh_reg[k+1];
            end
            sh_next[clnw_pkg::NIB_MAX-1] = '0;
            rem_next = rem_reg - clnw_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    assign nib.valid           = (rem_reg != '0);
    assign nib.nibble          = sh_reg[0].nib;
    assign nib.register_select = sh_reg[0].rs;
    assign nib.last            = (rem_reg == clnw_pkg::CNT_W'(1));

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= clnw_pkg::CNT_W'(clnw_pkg::NIB_MAX))
        else $error("nibble count beyond run length");

    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && nib.last && !load) |=> !nib.valid)
        else $error("nibble sent after last without a new run");

    a_build_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (bvld_reg && !adv) |=> (bvld_reg && $stable(bcnt_reg)))
        else $error("stalled build stage lost its run");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (rem_reg == '0 || (rem_reg == clnw_pkg::CNT_W'(1) && beat)))
        else $error("new run loaded over an unfinished one");

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for the character lcd nibble writer
`default_nettype none
module tb_top;
    import clnw_pkg::*;

    localparam logic [2:0] ACT_UNUSED   = 3'd7;
    localparam logic [1:0] CUR_SILENT_A = 2'd2;
    localparam logic [1:0] CUR_SILENT_B = 2'd3;
    localparam logic [7:0] CMD_FUNC_SET = 8'h28;
    localparam logic [7:0] CMD_DISP_OFF = 8'h08;
    localparam logic [7:0] CMD_CLEAR    = 8'h01;

    localparam int BUSY_ITEMS   = 294;
    localparam int HOLD_AT      = 80;
    localparam int PAUSE_AT     = 160;
    localparam int CALM_FROM    = 250;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 50;
    localparam int NUM_DIRECTED = 26;

    typedef struct packed {
        logic [3:0] nibble;
        logic       register_select;
        logic       last;
    } lcd_beat_t;

    typedef struct packed {
        req_t       r;
        logic       typed;
        logic [7:0] code;
        logic       code_rs;
    } dir_row_t;

    logic clk;
    logic rst_n;

    clnw_req_if req ();
    clnw_nib_if nib ();

    char_lcd_nibble_writer_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .nib   (nib.source)
    );

    lcd_beat_t predicted_run [$];
    lcd_beat_t expected_nibbles [$];

    int  error_count     = 0;
    int  requests_sent   = 0;
    int  silent_requests = 0;
    int  beats_checked   = 0;
    int  holds_requested = 0;
    int  burst_left      = 0;
    bit  calm_phase      = 1'b0;

    // expected field in the table only where it reads straight off the code
    dir_row_t directed_rows [NUM_DIRECTED] = '{
        '{'{ACT_INIT,    16'h0000, 6'd1,  2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_CMD,     16'h0000, 6'd1,  2'd1, CUR_OFF},      1'b1, 8'h00, 1'b0},
        '{'{ACT_CMD,     16'hFFFF, 6'd63, 2'd3, CUR_SILENT_B}, 1'b1, 8'hFF, 1'b0},
        '{'{ACT_CHAR,    16'h0041, 6'd1,  2'd1, CUR_OFF},      1'b1, 8'h41, 1'b1},
        '{'{ACT_CHAR,    16'hFF00, 6'd1,  2'd1, CUR_OFF},      1'b1, 8'h00, 1'b1},
        '{'{ACT_NUM,     16'd0,    6'd1,  2'd1, CUR_OFF},      1'b1, 8'h30, 1'b1},
        '{'{ACT_NUM,     16'd9,    6'd1,  2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_NUM,     16'd10,   6'd1,  2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_NUM,     16'd99,   6'd1,  2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_NUM,     16'd100,  6'd1,  2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_NUM,     16'd999,  6'd1,  2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_NUM,     16'd1000, 6'd1,  2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_NUM,     16'd9999, 6'd1,  2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_NUM,     16'd10000, 6'd1, 2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_NUM,     16'd65535, 6'd1, 2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_NUM_POS, 16'd65535, 6'd1, 2'd1, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_NUM_POS, 16'd0,    6'd40, 2'd2, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_POS,     16'h0000, 6'd1,  2'd1, CUR_OFF},      1'b1, 8'h80, 1'b0},
        '{'{ACT_POS,     16'h0000, 6'd40, 2'd2, CUR_OFF},      1'b1, 8'hE7, 1'b0},
        '{'{ACT_POS,     16'hFFFF, 6'd0,  2'd0, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_POS,     16'h0000, 6'd63, 2'd3, CUR_OFF},      1'b0, 8'h00, 1'b0},
        '{'{ACT_CURSOR,  16'h0000, 6'd1,  2'd1, CUR_OFF},      1'b1, 8'h0C, 1'b0},
        '{'{ACT_CURSOR,  16'hFFFF, 6'd1,  2'd1, CUR_BLINK},    1'b1, 8'h0F, 1'b0},
        '{'{ACT_CURSOR,  16'h0000, 6'd1,  2'd1, CUR_SILENT_A}, 1'b0, 8'h00, 1'b0},
        '{'{ACT_CURSOR,  16'h0000, 6'd1,  2'd1, CUR_SILENT_B}, 1'b0, 8'h00, 1'b0},
        '{'{ACT_UNUSED,  16'hFFFF, 6'd63, 2'd3, CUR_SILENT_B}, 1'b0, 8'h00, 1'b0}
    };

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #7200000;
        $display("timeout with %0d beats still awaited", expected_nibbles.size());
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void add_byte(input logic [7:0] b, input logic rs);
        predicted_run.push_back('{b[7:4], rs, 1'b0});
        predicted_run.push_back('{b[3:0], rs, 1'b0});
    endfunction

    function automatic logic [7:0] cursor_address(input logic [5:0] col, input logic [1:0] rw);
        logic [7:0] base;
        base = (rw == ROW_FIRST) ? LINE1_BASE : LINE2_BASE;
        return base + {2'b00, col} - 8'd1;
    endfunction

    // decimal digits, leading zeros dropped, zero itself still printed
    function automatic void add_decimal(input logic [15:0] v);
        int unsigned n;
        int unsigned div;
        n = v;
        for (div = 10000; div >= 1; div = div / 10)
        begin
            if (n >= div || div == 1)
            begin
                add_byte(ASCII_ZERO + 8'((n / div) % 10), 1'b1);
            end
        end
    endfunction

    function automatic void predict_nibbles(input req_t r);
        predicted_run.delete();
        case (r.action)
            ACT_INIT:
            begin
                predicted_run.push_back('{4'h3, 1'b0, 1'b0});
                predicted_run.push_back('{4'h3, 1'b0, 1'b0});
                predicted_run.push_back('{4'h3, 1'b0, 1'b0});
                predicted_run.push_back('{4'h2, 1'b0, 1'b0});
                add_byte(CMD_FUNC_SET, 1'b0);
                add_byte(CMD_DISP_OFF, 1'b0);
                add_byte(CMD_CUR_OFF, 1'b0);
                add_byte(CMD_CLEAR, 1'b0);
            end
            ACT_CMD:     add_byte(r.value[7:0], 1'b0);
            ACT_CHAR:    add_byte(r.value[7:0], 1'b1);
            ACT_NUM:     add_decimal(r.value);
            ACT_NUM_POS:
            begin
                add_byte(cursor_address(r.column, r.row), 1'b0);
                add_decimal(r.value);
            end
            ACT_POS:     add_byte(cursor_address(r.column, r.row), 1'b0);
            ACT_CURSOR:
            begin
                if (r.choice == CUR_OFF)
                    add_byte(CMD_CUR_OFF, 1'b0);
                else if (r.choice == CUR_BLINK)
                    add_byte(CMD_CUR_BLNK, 1'b0);
            end
            default: ;
        endcase
        if (predicted_run.size() > 0)
            predicted_run[predicted_run.size() - 1].last = 1'b1;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)       r.action = ACT_INIT;
        else if (pick < 20) r.action = ACT_CMD;
        else if (pick < 35) r.action = ACT_CHAR;
        else if (pick < 55) r.action = ACT_NUM;
        else if (pick < 70) r.action = ACT_NUM_POS;
        else if (pick < 85) r.action = ACT_POS;
        else if (pick < 95) r.action = ACT_CURSOR;
        else                r.action = ACT_UNUSED;
        // mix full-range values with digit-count boundaries and short numbers
        case ($urandom_range(0, 3))
            0: r.value = 16'($urandom_range(0, 99));
            1: r.value = 16'(($urandom_range(0, 1) == 0) ? 9 : 10)
                         * 16'(10 ** $urandom_range(0, 3))
                         - 16'($urandom_range(0, 1));
            default: r.value = 16'($urandom());
        endcase
        r.column = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(1, 40));
        r.row    = ($urandom_range(0, 6) == 0) ? 2'($urandom_range(0, 3))
                                               : 2'($urandom_range(1, 2));
        r.choice = 2'($urandom_range(0, 3));
        return r;
    endfunction

    task automatic rest_sender(input int cycles, input bit until_drained);
        req.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
        if (until_drained)
        begin
            while (expected_nibbles.size() != 0) @(posedge clk);
        end
    endtask

    task automatic maybe_rest();
        if (calm_phase)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        if ($urandom_range(0, 9) == 0)
            burst_left = $urandom_range(10, 30);
        else if ($urandom_range(0, 2) == 0)
            rest_sender($urandom_range(1, 18), 1'b0);
    endtask

    task automatic offer_request(input req_t r, input logic typed,
                                 input logic [7:0] code, input logic code_rs);
        req.valid         <= 1'b1;
        req.action        <= r.action;
        req.value         <= r.value;
        req.column        <= r.column;
        req.row           <= r.row;
        req.cursor_choice <= r.choice;
        do @(posedge clk); while (req.ready !== 1'b1);
        if (typed)
        begin
            predicted_run.delete();
            add_byte(code, code_rs);
            predicted_run[1].last = 1'b1;
        end
        else
        begin
            predict_nibbles(r);
        end
        foreach (predicted_run[i])
            expected_nibbles.push_back(predicted_run[i]);
        requests_sent++;
        if (predicted_run.size() == 0)
            silent_requests++;
    endtask

    // nibble side: random ready bursts, one long hold-off on request
    initial
    begin
        int   span;
        int   holds_served;
        logic level;
        holds_served = 0;
        level        = 1'b0;
        nib.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (holds_requested != holds_served)
            begin
                level = 1'b0;
                span  = HOLD_CYCLES;
                holds_served++;
            end
            else if (calm_phase)
            begin
                level = 1'b1;
                span  = 1;
            end
            else if (level && $urandom_range(0, 2) != 0)
            begin
                level = 1'b0;
                span  = $urandom_range(1, 18);
            end
            else
            begin
                level = 1'b1;
                span  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                    : $urandom_range(1, 18);
            end
            nib.ready <= level;
            repeat (span) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        lcd_beat_t want;
        if (rst_n && nib.valid === 1'b1 && nib.ready === 1'b1)
        begin
            if (expected_nibbles.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat nibble %h rs %b last %b",
                                          nib.nibble, nib.register_select, nib.last));
            end
            else
            begin
                want = expected_nibbles.pop_front();
                beats_checked++;
                if (nib.nibble !== want.nibble || nib.register_select !== want.register_select
                    || nib.last !== want.last)
                begin
                    report_mismatch($sformatf("got nibble %h rs %b last %b, want %h %b %b",
                                              nib.nibble, nib.register_select, nib.last,
                                              want.nibble, want.register_select, want.last));
                end
            end
        end
    end

    // request side: directed table, then random requests
    initial
    begin
        req_t r;
        int   busy;
        bit   hold_asked;
        bit   paused;
        busy       = 0;
        hold_asked = 1'b0;
        paused     = 1'b0;
        req.valid         <= 1'b0;
        req.action        <= ACT_INIT;
        req.value         <= '0;
        req.column        <= '0;
        req.row           <= '0;
        req.cursor_choice <= '0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_request(directed_rows[i].r, directed_rows[i].typed,
                          directed_rows[i].code, directed_rows[i].code_rs);
            maybe_rest();
        end

        while (busy < BUSY_ITEMS)
        begin
            r = random_request();
            offer_request(r, 1'b0, 8'h00, 1'b0);
            busy++;
            if (busy == HOLD_AT && !hold_asked)
            begin
                // keep offering back to back while the nibble side is held off
                holds_requested++;
                burst_left = 40;
                hold_asked = 1'b1;
            end
            else if (busy == PAUSE_AT && !paused)
            begin
                rest_sender(1, 1'b1);
                paused = 1'b1;
            end
            else if (busy >= CALM_FROM)
            begin
                calm_phase = 1'b1;
            end
            else
            begin
                maybe_rest();
            end
        end

        rest_sender(1, 1'b1);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d requests sent (%0d with no output), %0d nibble beats checked",
                 requests_sent, silent_requests, beats_checked);
        $display("run included a long output hold-off and a full drain pause");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
hdl/clnw_pkg.sv
hdl/clnw_req_if.sv
hdl/clnw_nib_if.sv
hdl/char_lcd_nibble_writer_unit.sv
dv/tb_top.sv
